@@ rtl/ffj_pkg.sv @@
// ----------------------------------------------------------------------------
// ffj_pkg
// Field widths, output caps and degree codes for the fractional flow jet.
// ----------------------------------------------------------------------------
package ffj_pkg;

	localparam int SAT_W   = 17;  // saturation field
	localparam int RATIO_W = 24;  // viscosity ratio field
	localparam int FLOW_W  = 17;  // fractional flow field
	localparam int DERIV_W = 32;  // derivative fields
	localparam int DEG_W   = 2;   // derivative degree register
	localparam int QUO_W   = 33;  // quotient bits, one guard bit for rounding
	localparam int LIMB_W  = 32;  // multiplier limb

	localparam logic [QUO_W:0] FLOW_CAP = 34'd131071;
	localparam logic [QUO_W:0] POS_CAP  = 34'd2147483647;
	localparam logic [QUO_W:0] NEG_CAP  = 34'd2147483648;

	localparam logic [DEG_W-1:0] DEG_VALUE = 2'd0;
	localparam logic [DEG_W-1:0] DEG_GRAD  = 2'd1;
	localparam logic [DEG_W-1:0] DEG_HESS  = 2'd2;

endpackage

@@ rtl/ffj_if.sv @@
// ----------------------------------------------------------------------------
// ffj channel interfaces
// Point request, result request and degree write channels.
// ----------------------------------------------------------------------------
interface ffj_in_if;
	logic                            valid;
	logic                            ready;
	logic [ffj_pkg::SAT_W-1:0]       saturation;
	logic [ffj_pkg::RATIO_W-1:0]     visc_ratio;
	modport source (output valid, saturation, visc_ratio, input ready);
	modport sink   (input valid, saturation, visc_ratio, output ready);
endinterface

interface ffj_out_if;
	logic                               valid;
	logic                               ready;
	logic [ffj_pkg::FLOW_W-1:0]         frac_flow;
	logic signed [ffj_pkg::DERIV_W-1:0] dflow_ds;
	logic signed [ffj_pkg::DERIV_W-1:0] dflow_dr;
	logic signed [ffj_pkg::DERIV_W-1:0] d2flow_dss;
	logic signed [ffj_pkg::DERIV_W-1:0] d2flow_dsr;
	logic signed [ffj_pkg::DERIV_W-1:0] d2flow_drr;
	logic                               zero_denominator;
	modport source (output valid, frac_flow, dflow_ds, dflow_dr, d2flow_dss, d2flow_dsr,
		d2flow_drr, zero_denominator, input ready);
	modport sink   (input valid, frac_flow, dflow_ds, dflow_dr, d2flow_dss, d2flow_dsr,
		d2flow_drr, zero_denominator, output ready);
endinterface

interface ffj_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [ffj_pkg::DEG_W-1:0]   data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

@@ rtl/ffj_mul.sv @@
// ----------------------------------------------------------------------------
// ffj_mul
// Unsigned multiplier cut into limb products, two register stages.
// ----------------------------------------------------------------------------
module ffj_mul #(
	parameter int AW = 8,
	parameter int BW = 8
) (
	input  logic             clk,
	input  logic             en,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] p_s2
);
	localparam int LW   = ffj_pkg::LIMB_W;
	localparam int NA   = (AW + LW - 1) / LW;
	localparam int NB   = (BW + LW - 1) / LW;
	localparam int PADW = (NA + NB) * LW;

	logic [NA*LW-1:0]  a_pad;
	logic [NB*LW-1:0]  b_pad;
	logic [2*LW-1:0]   pp_s1 [NA][NB];
	logic [PADW-1:0]   acc;

	assign a_pad = (NA*LW)'(a);
	assign b_pad = (NB*LW)'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= (2*LW)'(a_pad[i*LW +: LW]) * (2*LW)'(b_pad[j*LW +: LW]);
				end
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (PADW'(pp_s1[i][j]) << (LW * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= acc[AW+BW-1:0];
		end
	end
endmodule

@@ rtl/ffj_div.sv @@
// ----------------------------------------------------------------------------
// ffj_div
// Pipelined restoring divider, one quotient bit per stage, rounds half up,
// saturates and applies the sign.
// ----------------------------------------------------------------------------
module ffj_div #(
	parameter int                        XW = 8,
	parameter int                        SH = 8,
	parameter int                        DW = 8,
	parameter int                        OW = 32,
	parameter logic [ffj_pkg::QUO_W:0]   POS_CAP = 34'd2147483647,
	parameter logic [ffj_pkg::QUO_W:0]   NEG_CAP = 34'd2147483648
) (
	input  logic          clk,
	input  logic          en,
	input  logic [XW-1:0] x,
	input  logic [DW-1:0] d,
	input  logic          neg,
	output logic [OW-1:0] q_o
);
	localparam int QB = ffj_pkg::QUO_W;
	localparam int NW = XW + SH;
	localparam int HW = NW - QB;
	localparam int CW = (HW > DW) ? HW : DW;

	logic [NW-1:0] nfull;
	logic [HW-1:0] hi;
	logic          ovf;

	logic [DW-1:0] rem_s [0:QB-1];
	logic [DW-1:0] d_s   [0:QB-1];
	logic [QB-1:0] lo_s  [0:QB-1];
	logic [QB-1:0] q_s   [0:QB];
	logic          neg_s [0:QB];
	logic          ovf_s [0:QB];

	logic [QB:0]   qr;
	logic [QB:0]   cap;
	logic [QB:0]   mag;
	logic [QB:0]   res;

	assign nfull = NW'(x) << SH;
	assign hi    = nfull[NW-1:QB];
	assign ovf   = CW'(hi) >= CW'(d);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ovf ? '0 : DW'(hi);
			d_s[0]   <= d;
			lo_s[0]  <= nfull[QB-1:0];
			q_s[0]   <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= ovf;
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_step
		logic [DW:0] r1;
		logic        ge;
		assign r1 = {rem_s[j-1], lo_s[j-1][QB-1]};
		assign ge = r1 >= {1'b0, d_s[j-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[j]   <= q_s[j-1] | (ge ? (QB'(1) << (QB - j)) : '0);
				neg_s[j] <= neg_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
			end
		end

		if (j < QB) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= ge ? DW'(r1 - {1'b0, d_s[j-1]}) : DW'(r1);
					d_s[j]   <= d_s[j-1];
					lo_s[j]  <= lo_s[j-1] << 1;
				end
			end
		end
	end

	// round half up from the guard bit, then clamp to the signed cap
	always_comb begin
		qr  = ((QB+1)'(q_s[QB]) + (QB+1)'(1)) >> 1;
		cap = neg_s[QB] ? NEG_CAP : POS_CAP;
		mag = (ovf_s[QB] || qr > cap) ? cap : qr;
		res = neg_s[QB] ? ((QB+1)'(0) - mag) : mag;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_o <= res[OW-1:0];
		end
	end
endmodule

@@ rtl/fractional_flow_jet.sv @@
// ----------------------------------------------------------------------------
// fractional_flow_jet
// Quadratic fractional flow fo = s^2/(s^2 + r(1-s)^2) with first and second
// derivatives, fixed point, one point per clock unless the result stalls.
//
//   channel  dir  handshake      payload
//   point    in   valid/ready    saturation, visc_ratio
//   result   out  valid/ready    frac_flow, five derivatives, zero_denominator
//   cfg      in   valid/ready    data = derivative_degree
//
// One point is taken every cycle unless the result stalls; the pipeline is
// four two-stage limb multipliers in series, then 33-stage quotient pipelines.
// Reset clears the valid bits and sets the degree to two; no clearing pass.
// A stalled result freezes the whole pipeline, and point.ready drops with it.
// ----------------------------------------------------------------------------
module fractional_flow_jet #(
	parameter int FRAC_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	ffj_in_if.sink       point,
	ffj_out_if.source    result,
	ffj_cfg_if.sink      cfg
);
	localparam int F    = FRAC_BITS;
	localparam int RW   = ffj_pkg::RATIO_W;
	localparam int SW   = F + 1;
	localparam int XW   = (SW > ffj_pkg::SAT_W) ? SW : ffj_pkg::SAT_W;
	localparam int S2W  = 2 * SW;
	localparam int AW_  = S2W + F;
	localparam int BW_  = RW + S2W;
	localparam int MW   = ((AW_ > BW_) ? AW_ : BW_) + 1;
	localparam int PW_  = SW + F;
	localparam int QW_  = RW + SW;
	localparam int PQW  = (PW_ > QW_) ? PW_ : QW_;
	localparam int FSW  = S2W + 2;
	localparam int T2W  = FSW + PQW;
	localparam int TW   = SW + MW;
	localparam int EW   = ((TW > T2W) ? TW : T2W) + 1;
	localparam int M2W  = 2 * MW;
	localparam int M3W  = 3 * MW;
	localparam int XDSW = RW + S2W;
	localparam int XDRW = 2 * S2W;
	localparam int SU2W = 2 * S2W;
	localparam int XSRW = S2W + MW;
	localparam int XRRW = SU2W + S2W;
	localparam int XSSW = RW + EW;
	localparam int LAT  = 13 + ffj_pkg::QUO_W;

	logic                           en;
	logic [ffj_pkg::DEG_W-1:0]      deg_q;
	logic                           v_s [1:LAT];

	logic [XW-1:0]  sx, one_x, sc;
	logic [SW-1:0]  sv_s [1:8];
	logic [SW-1:0]  uv_s [1:8];
	logic [RW-1:0]  rv_s [1:9];

	logic [S2W-1:0] s2_m, u2_m, su_m;
	logic [QW_-1:0] ru_m;
	logic [S2W-1:0] s2_s [4:11];
	logic [S2W-1:0] su_s [4:6];
	logic [S2W-1:0] u2_s [4:6];
	logic           n2_s [4:8];

	logic [PQW-1:0] pv, qv, pq_mag;
	logic           n2_c;
	logic [FSW-1:0] four_su;

	logic [BW_-1:0]  b_m;
	logic [SU2W-1:0] su2_m;
	logic [XDSW-1:0] xds_m;
	logic [XDRW-1:0] xdr_m;
	logic [T2W-1:0]  t2_m;

	logic [MW-1:0]   av, bv, m_c, ab_mag;
	logic            ab_n;
	logic [MW-1:0]   m_s   [6:11];
	logic            abn_s [6:11];
	logic [MW-1:0]   abm_s6;
	logic [SU2W-1:0] su2_s6;
	logic [XDSW-1:0] xds_s [6:11];
	logic [XDRW-1:0] xdr_s [6:11];
	logic [T2W-1:0]  t2_s  [6:8];
	logic            z_s   [6:LAT];

	logic [SW-1:0]   dus;
	logic [M2W-1:0]  m2_m;
	logic [TW-1:0]   t_m;
	logic [XSRW-1:0] xsr_m;
	logic [XRRW-1:0] xrr_m;

	logic            n1, tn2;
	logic [EW-1:0]   ta, tb, e_c;
	logic            e_n;
	logic [EW-1:0]   e_s9;
	logic            en_s  [9:11];
	logic [M2W-1:0]  m2_s  [9:11];
	logic [XSRW-1:0] xsr_s [9:11];
	logic [XRRW-1:0] xrr_s [9:11];

	logic [M3W-1:0]  m3_m;
	logic [XSSW-1:0] xss_m;

	logic [ffj_pkg::FLOW_W-1:0]  fo_q;
	logic [ffj_pkg::DERIV_W-1:0] ds_q, dr_q, ss_q, sr_q, rr_q;
	logic                        d1, d2, z;

	// -------------------------------------------------------------- control
	assign en          = !v_s[LAT] || result.ready;
	assign point.ready = en;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= ffj_pkg::DEG_HESS;
		end else if (cfg.valid) begin
			deg_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[1] <= point.valid;
			for (int i = 2; i <= LAT; i++) v_s[i] <= v_s[i-1];
		end
	end

	// -------------------------------------------------------------- stage 1
	// clamp saturation to one
	assign sx    = XW'(point.saturation);
	assign one_x = XW'(1) << F;
	assign sc    = (sx > one_x) ? one_x : sx;

	// ------------------------------------------------ multiplier level one
	ffj_mul #(.AW(SW), .BW(SW)) u_s2 (.clk, .en, .a(sv_s[1]), .b(sv_s[1]), .p_s2(s2_m));
	ffj_mul #(.AW(SW), .BW(SW)) u_u2 (.clk, .en, .a(uv_s[1]), .b(uv_s[1]), .p_s2(u2_m));
	ffj_mul #(.AW(SW), .BW(SW)) u_su (.clk, .en, .a(sv_s[1]), .b(uv_s[1]), .p_s2(su_m));
	ffj_mul #(.AW(RW), .BW(SW)) u_ru (.clk, .en, .a(rv_s[1]), .b(uv_s[1]), .p_s2(ru_m));

	// stage 3: s*2^F against r*u for the d2ss bracket
	always_comb begin
		pv      = PQW'(sv_s[3]) << F;
		qv      = PQW'(ru_m);
		n2_c    = qv > pv;
		pq_mag  = n2_c ? (qv - pv) : (pv - qv);
		four_su = FSW'(su_m) << 2;
	end

	// ------------------------------------------------ multiplier level two
	ffj_mul #(.AW(RW), .BW(S2W))   u_b   (.clk, .en, .a(rv_s[3]), .b(u2_m), .p_s2(b_m));
	ffj_mul #(.AW(S2W), .BW(S2W))  u_su2 (.clk, .en, .a(su_m), .b(su_m), .p_s2(su2_m));
	ffj_mul #(.AW(RW), .BW(S2W))   u_xds (.clk, .en, .a(rv_s[3]), .b(su_m), .p_s2(xds_m));
	ffj_mul #(.AW(S2W), .BW(S2W))  u_xdr (.clk, .en, .a(s2_m), .b(u2_m), .p_s2(xdr_m));
	ffj_mul #(.AW(FSW), .BW(PQW))  u_t2  (.clk, .en, .a(four_su), .b(pq_mag), .p_s2(t2_m));

	// stage 5: denominator and the sign of s^2 - r u^2
	always_comb begin
		av     = MW'(s2_s[5]) << F;
		bv     = MW'(b_m);
		m_c    = av + bv;
		ab_n   = av < bv;
		ab_mag = ab_n ? (bv - av) : (av - bv);
	end

	// ---------------------------------------------- multiplier level three
	assign dus = (sv_s[6] > uv_s[6]) ? (sv_s[6] - uv_s[6]) : (uv_s[6] - sv_s[6]);

	ffj_mul #(.AW(MW), .BW(MW))    u_m2  (.clk, .en, .a(m_s[6]), .b(m_s[6]), .p_s2(m2_m));
	ffj_mul #(.AW(SW), .BW(MW))    u_t   (.clk, .en, .a(dus), .b(m_s[6]), .p_s2(t_m));
	ffj_mul #(.AW(S2W), .BW(MW))   u_xsr (.clk, .en, .a(su_s[6]), .b(abm_s6), .p_s2(xsr_m));
	ffj_mul #(.AW(SU2W), .BW(S2W)) u_xrr (.clk, .en, .a(su2_s6), .b(u2_s[6]), .p_s2(xrr_m));

	// stage 8: e = (u-s)m - 4su(s*2^F - r u), as sign and magnitude
	always_comb begin
		n1  = sv_s[8] > uv_s[8];
		tn2 = !n2_s[8];
		ta  = EW'(t_m);
		tb  = EW'(t2_s[8]);
		if (n1 == tn2) begin
			e_c = ta + tb;
			e_n = n1;
		end else if (ta >= tb) begin
			e_c = ta - tb;
			e_n = n1;
		end else begin
			e_c = tb - ta;
			e_n = tn2;
		end
	end

	// ----------------------------------------------- multiplier level four
	ffj_mul #(.AW(M2W), .BW(MW)) u_m3  (.clk, .en, .a(m2_s[9]), .b(m_s[9]), .p_s2(m3_m));
	ffj_mul #(.AW(RW), .BW(EW))  u_xss (.clk, .en, .a(rv_s[9]), .b(e_s9), .p_s2(xss_m));

	// ------------------------------------------------------- side registers
	always_ff @(posedge clk) begin
		if (en) begin
			sv_s[1] <= SW'(sc);
			uv_s[1] <= SW'(one_x - sc);
			rv_s[1] <= point.visc_ratio;
			for (int i = 2; i <= 8; i++) begin
				sv_s[i] <= sv_s[i-1];
				uv_s[i] <= uv_s[i-1];
			end
			for (int i = 2; i <= 9; i++) rv_s[i] <= rv_s[i-1];

			s2_s[4] <= s2_m;
			for (int i = 5; i <= 11; i++) s2_s[i] <= s2_s[i-1];
			su_s[4] <= su_m;
			u2_s[4] <= u2_m;
			for (int i = 5; i <= 6; i++) begin
				su_s[i] <= su_s[i-1];
				u2_s[i] <= u2_s[i-1];
			end
			n2_s[4] <= n2_c;
			for (int i = 5; i <= 8; i++) n2_s[i] <= n2_s[i-1];

			m_s[6]   <= m_c;
			abn_s[6] <= ab_n;
			abm_s6   <= ab_mag;
			su2_s6   <= su2_m;
			xds_s[6] <= xds_m;
			xdr_s[6] <= xdr_m;
			t2_s[6]  <= t2_m;
			z_s[6]   <= (m_c == '0);
			for (int i = 7; i <= 11; i++) begin
				m_s[i]   <= m_s[i-1];
				abn_s[i] <= abn_s[i-1];
				xds_s[i] <= xds_s[i-1];
				xdr_s[i] <= xdr_s[i-1];
			end
			for (int i = 7; i <= 8; i++) t2_s[i] <= t2_s[i-1];
			for (int i = 7; i <= LAT; i++) z_s[i] <= z_s[i-1];

			e_s9     <= e_c;
			en_s[9]  <= e_n;
			m2_s[9]  <= m2_m;
			xsr_s[9] <= xsr_m;
			xrr_s[9] <= xrr_m;
			for (int i = 10; i <= 11; i++) begin
				en_s[i]  <= en_s[i-1];
				m2_s[i]  <= m2_s[i-1];
				xsr_s[i] <= xsr_s[i-1];
				xrr_s[i] <= xrr_s[i-1];
			end
		end
	end

	// ------------------------------------------------------------ quotients
	ffj_div #(.XW(S2W), .SH(2*F+1), .DW(MW), .OW(ffj_pkg::FLOW_W),
		.POS_CAP(ffj_pkg::FLOW_CAP), .NEG_CAP(ffj_pkg::FLOW_CAP)) u_div_fo (
		.clk, .en, .x(s2_s[11]), .d(m_s[11]), .neg(1'b0), .q_o(fo_q));

	ffj_div #(.XW(XDSW), .SH(4*F+2), .DW(M2W), .OW(ffj_pkg::DERIV_W),
		.POS_CAP(ffj_pkg::POS_CAP), .NEG_CAP(ffj_pkg::NEG_CAP)) u_div_ds (
		.clk, .en, .x(xds_s[11]), .d(m2_s[11]), .neg(1'b0), .q_o(ds_q));

	ffj_div #(.XW(XDRW), .SH(3*F+1), .DW(M2W), .OW(ffj_pkg::DERIV_W),
		.POS_CAP(ffj_pkg::POS_CAP), .NEG_CAP(ffj_pkg::NEG_CAP)) u_div_dr (
		.clk, .en, .x(xdr_s[11]), .d(m2_s[11]), .neg(1'b1), .q_o(dr_q));

	ffj_div #(.XW(XSSW), .SH(5*F+2), .DW(M3W), .OW(ffj_pkg::DERIV_W),
		.POS_CAP(ffj_pkg::POS_CAP), .NEG_CAP(ffj_pkg::NEG_CAP)) u_div_ss (
		.clk, .en, .x(xss_m), .d(m3_m), .neg(en_s[11]), .q_o(ss_q));

	ffj_div #(.XW(XSRW), .SH(5*F+2), .DW(M3W), .OW(ffj_pkg::DERIV_W),
		.POS_CAP(ffj_pkg::POS_CAP), .NEG_CAP(ffj_pkg::NEG_CAP)) u_div_sr (
		.clk, .en, .x(xsr_s[11]), .d(m3_m), .neg(abn_s[11]), .q_o(sr_q));

	ffj_div #(.XW(XRRW), .SH(4*F+2), .DW(M3W), .OW(ffj_pkg::DERIV_W),
		.POS_CAP(ffj_pkg::POS_CAP), .NEG_CAP(ffj_pkg::NEG_CAP)) u_div_rr (
		.clk, .en, .x(xrr_s[11]), .d(m3_m), .neg(1'b0), .q_o(rr_q));

	// --------------------------------------------------------------- output
	// degree three acts as two; a zero denominator drops every value
	assign z  = z_s[LAT];
	assign d1 = (deg_q != ffj_pkg::DEG_VALUE) && !z;
	assign d2 = (deg_q != ffj_pkg::DEG_VALUE) && (deg_q != ffj_pkg::DEG_GRAD) && !z;

	assign result.valid            = v_s[LAT];
	assign result.frac_flow        = z ? '0 : fo_q;
	assign result.dflow_ds         = d1 ? ds_q : '0;
	assign result.dflow_dr         = d1 ? dr_q : '0;
	assign result.d2flow_dss       = d2 ? ss_q : '0;
	assign result.d2flow_dsr       = d2 ? sr_q : '0;
	assign result.d2flow_drr       = d2 ? rr_q : '0;
	assign result.zero_denominator = z;
endmodule
